>>> hw/rtl/lph_pkg.sv
// Shared constants and codes for the linear-probe key-value table.
package lph_pkg;

	// Default number of slots in the table.
	localparam int unsigned DEFAULT_SLOTS = 1024;

	// Payload widths.
	localparam int unsigned KEY_W    = 32;
	localparam int unsigned VALUE_W  = 32;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned COUNT_W  = 11;

	// Value returned by a lookup that misses.
	localparam logic [VALUE_W-1:0] MISS_VALUE = 32'd123456789;

	// Operation codes.
	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

	// Result status codes.
	localparam logic [STATUS_W-1:0] STAT_INSERTED  = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_REPLACED  = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_FOUND     = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd4;

endpackage

>>> hw/rtl/linear_probe_hash_table.sv
// Top level of the linear-probe key-value table: probe sequencer around one slot memory.
// The table holds SLOTS slots of {occupied, key, value} in one synchronous memory. After
// reset a clearing pass writes every slot free, one slot a cycle, and the block takes no
// beat until it ends. Each operation then reads its home slot and probes on from there; the
// memory read of one slot overlaps the compare of the previous one, so the probe loop runs
// at one slot per cycle through the single read port.
// When SLOTS is not a power of two the home slot is the key modulo SLOTS, worked out by a
// reciprocal multiplication in a multiply, a quotient and a remainder step.
// A finished result waits in the output register, and the next beat may be taken while
// it waits.
module linear_probe_hash_table
	#(
		parameter int unsigned SLOTS = lph_pkg::DEFAULT_SLOTS
	)
	(
		input  logic                          clk,
		input  logic                          arst_n,
		// Request channel.
		input  logic                          in_valid,
		output logic                          in_stall,
		input  logic                          opcode,
		input  logic [lph_pkg::KEY_W-1:0]     key,
		input  logic [lph_pkg::VALUE_W-1:0]   value,
		// Result channel.
		output logic                          out_valid,
		input  logic                          out_stall,
		output logic [lph_pkg::STATUS_W-1:0]  status,
		output logic [lph_pkg::VALUE_W-1:0]   value_out,
		output logic [lph_pkg::COUNT_W-1:0]   occupied_count
	);

	import lph_pkg::*;

	localparam int unsigned IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam bit          POW2   = ((SLOTS & (SLOTS - 1)) == 0);
	localparam int unsigned ENTRY_W = 1 + KEY_W + VALUE_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

	// Reciprocal of SLOTS scaled by 2^48 and rounded up; exact for any 32-bit key.
	localparam logic [63:0] RECIP    = ((64'd1 << 48) + 64'(SLOTS) - 64'd1) / 64'(SLOTS);
	localparam logic [31:0] RECIP_LO = RECIP[31:0];
	localparam logic [15:0] RECIP_HI = RECIP[47:32];

	// Steps of the home slot calculation.
	localparam logic [1:0] HOME_STEP_MUL  = 2'd0;
	localparam logic [1:0] HOME_STEP_QUOT = 2'd1;
	localparam logic [1:0] HOME_STEP_REM  = 2'd2;

	// Sequencer state codes.
	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_HOME  = 3'd2;
	localparam logic [2:0] S_READ  = 3'd3;
	localparam logic [2:0] S_PROBE = 3'd4;
	localparam logic [2:0] S_WAIT  = 3'd5;

	logic [2:0]          state_q;
	logic [IDX_W-1:0]    slot_q;
	logic [IDX_W-1:0]    probe_q;
	logic [1:0]          step_q;
	logic [COUNT_W-1:0]  count_q;

	logic                op_q;
	logic [KEY_W-1:0]    key_q;
	logic [VALUE_W-1:0]  value_q;

	logic [63:0]         mul_lo_q;
	logic [KEY_W-1:0]    quot_q;

	logic [ENTRY_W-1:0]  mem [SLOTS];
	logic [ENTRY_W-1:0]  rd_q;
	logic [IDX_W-1:0]    rd_addr;
	logic                wr_en;
	logic [IDX_W-1:0]    wr_addr;
	logic [ENTRY_W-1:0]  wr_data;

	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [VALUE_W-1:0]  value_out_q;
	logic [COUNT_W-1:0]  occ_out_q;

	logic [STATUS_W-1:0] pend_status_q;
	logic [VALUE_W-1:0]  pend_value_q;
	logic [COUNT_W-1:0]  pend_count_q;

	logic                accept;
	logic                out_free;
	logic [IDX_W-1:0]    next_slot;
	logic [47:0]         quot_sum;
	logic [KEY_W-1:0]    home_rem;
	logic                slot_free;
	logic                key_hit;
	logic                last_probe;
	logic                probe_done;
	logic [STATUS_W-1:0] res_status;
	logic [VALUE_W-1:0]  res_value;
	logic [COUNT_W-1:0]  res_count;
	logic                load_out;
	logic                load_pend;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// Next slot on the probe path, wrapping at the end of the table.
	assign next_slot = (slot_q == LAST_IDX) ? '0 : slot_q + 1'b1;

	// Quotient of the key by SLOTS from the split reciprocal product, then the remainder.
	assign quot_sum = ({16'd0, key_q} * {32'd0, RECIP_HI}) + {16'd0, mul_lo_q[63:32]};
	assign home_rem = key_q - (quot_q * KEY_W'(SLOTS));

	// Compare of the slot that the memory has just returned.
	assign slot_free  = !rd_q[ENTRY_W-1];
	assign key_hit    = (rd_q[KEY_W+VALUE_W-1:VALUE_W] == key_q);
	assign last_probe = (probe_q == LAST_IDX);
	assign probe_done = slot_free || key_hit || last_probe;

	// Result of the operation once its probe ends, and the memory write for the clear pass or a put.
	always_comb begin
		res_status = STAT_NOT_FOUND;
		res_value  = MISS_VALUE;
		res_count  = count_q;
		wr_en      = 1'b0;
		wr_addr    = slot_q;
		wr_data    = {1'b1, key_q, value_q};
		if (state_q == S_CLEAR) begin
			wr_en   = 1'b1;
			wr_data = '0;
		end else if (state_q == S_PROBE) begin
			if (op_q == OP_PUT) begin
				res_value = '0;
				if (slot_free) begin
					res_status = STAT_INSERTED;
					res_count  = count_q + 1'b1;
					wr_en      = 1'b1;
				end else if (key_hit) begin
					res_status = STAT_REPLACED;
					wr_en      = 1'b1;
				end else begin
					res_status = STAT_FULL;
				end
			end else begin
				if (!slot_free && key_hit) begin
					res_status = STAT_FOUND;
					res_value  = rd_q[VALUE_W-1:0];
				end
			end
		end
	end

	// Read address: the home slot on the first probe, then the slot after the one compared.
	assign rd_addr = (state_q == S_PROBE) ? next_slot : slot_q;

	assign load_out  = ((state_q == S_PROBE) && probe_done && out_free) ||
	                   ((state_q == S_WAIT) && out_free);
	assign load_pend = (state_q == S_PROBE) && probe_done && !out_free;

	// Slot memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en && ((state_q == S_CLEAR) || probe_done)) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	// Partial products of the home slot calculation.
	always_ff @(posedge clk) begin
		if (state_q == S_HOME) begin
			if (step_q == HOME_STEP_MUL) begin
				mul_lo_q <= {32'd0, key_q} * {32'd0, RECIP_LO};
			end
			if (step_q == HOME_STEP_QUOT) begin
				quot_q <= quot_sum[47:16];
			end
		end
	end

	// Probe sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			slot_q  <= '0;
			probe_q <= '0;
			step_q  <= '0;
			count_q <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					slot_q <= next_slot;
					if (slot_q == LAST_IDX) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						probe_q <= '0;
						step_q  <= HOME_STEP_MUL;
						if (POW2) begin
							slot_q  <= key[IDX_W-1:0];
							state_q <= S_READ;
						end else begin
							slot_q  <= '0;
							state_q <= S_HOME;
						end
					end
				end
				S_HOME: begin
					step_q <= step_q + 1'b1;
					if (step_q == HOME_STEP_REM) begin
						slot_q  <= home_rem[IDX_W-1:0];
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_PROBE;
				end
				S_PROBE: begin
					if (probe_done) begin
						count_q <= res_count;
						state_q <= out_free ? S_IDLE : S_WAIT;
					end else begin
						slot_q  <= next_slot;
						probe_q <= probe_q + 1'b1;
					end
				end
				S_WAIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Request registers, captured on each accepted beat.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= opcode;
			key_q   <= key;
			value_q <= value;
		end
	end

	// Output beat valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload and the holding register used while the output is stalled.
	always_ff @(posedge clk) begin
		if (load_pend) begin
			pend_status_q <= res_status;
			pend_value_q  <= res_value;
			pend_count_q  <= res_count;
		end
		if (load_out) begin
			if (state_q == S_WAIT) begin
				status_q    <= pend_status_q;
				value_out_q <= pend_value_q;
				occ_out_q   <= pend_count_q;
			end else begin
				status_q    <= res_status;
				value_out_q <= res_value;
				occ_out_q   <= res_count;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign value_out      = value_out_q;
	assign occupied_count = occ_out_q;

endmodule
